// File: design/pfc_pkg.sv
package pfc_pkg;

  // Key square geometry and letter codes
  localparam int unsigned SIDE       = 5;
  localparam int unsigned LETTER_W   = 5;
  localparam int unsigned POS_W      = 3;
  localparam int unsigned ROWS2_W    = 2 * SIDE * LETTER_W;
  localparam int unsigned ROW1_W     = SIDE * LETTER_W;
  localparam int unsigned CFG_DATA_W = ROWS2_W;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [LETTER_W-1:0] LETTER_I   = 5'd8;
  localparam logic [LETTER_W-1:0] LETTER_J   = 5'd9;
  localparam logic [LETTER_W-1:0] LETTER_MAX = 5'd25;

  typedef logic [LETTER_W-1:0] letter_t;
  typedef logic [POS_W-1:0]    pos_t;

  // Square as [row][col] cells; cell (0,0) sits in the lowest bits
  typedef logic [SIDE-1:0][SIDE-1:0][LETTER_W-1:0] grid_t;

  typedef enum logic {
    CMD_ENCRYPT = 1'b0,
    CMD_DECRYPT = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS_0_1 = 2'd0,
    REG_ROWS_2_3 = 2'd1,
    REG_ROW_4    = 2'd2,
    REG_NONE     = 2'd3
  } cfg_reg_t;

  // Result of one lookup lane
  typedef struct packed {
    logic found;
    pos_t row;
    pos_t col;
  } lane_res_t;

  // One finished result item
  typedef struct packed {
    letter_t first_out;
    letter_t second_out;
    logic    not_found;
  } out_res_t;

  // Step one place forward or back around the square, wrapping
  function automatic pos_t step_pos(input pos_t p, input cmd_t cmd);
    pos_t r;
    if (cmd == CMD_ENCRYPT) begin
      r = (p == pos_t'(SIDE - 1)) ? pos_t'(0) : pos_t'(p + pos_t'(1));
    end else begin
      r = (p == pos_t'(0)) ? pos_t'(SIDE - 1) : pos_t'(p - pos_t'(1));
    end
    return r;
  endfunction

endpackage

// File: design/pfc_in_if.sv
interface pfc_in_if;
  logic                     valid;
  logic                     ready;
  logic                     cmd;
  logic [pfc_pkg::LETTER_W-1:0] first_letter;
  logic [pfc_pkg::LETTER_W-1:0] second_letter;

  modport source (output valid, output cmd, output first_letter, output second_letter,
                  input ready);
  modport sink   (input valid, input cmd, input first_letter, input second_letter,
                  output ready);
endinterface

// File: design/pfc_out_if.sv
interface pfc_out_if;
  logic                     valid;
  logic                     ready;
  logic [pfc_pkg::LETTER_W-1:0] first_out;
  logic [pfc_pkg::LETTER_W-1:0] second_out;
  logic                     not_found;

  modport source (output valid, output first_out, output second_out, output not_found,
                  input ready);
  modport sink   (input valid, input first_out, input second_out, input not_found,
                  output ready);
endinterface

// File: design/pfc_lane.sv
module pfc_lane (
  input  pfc_pkg::grid_t     grid,
  input  pfc_pkg::letter_t   letter,
  output pfc_pkg::lane_res_t res
);

  pfc_pkg::letter_t folded;

  // Fold J onto I before the lookup
  assign folded = (letter == pfc_pkg::LETTER_J) ? pfc_pkg::LETTER_I : letter;

  // Compare all cells at once; scan backward so the first row-major hit wins
  always_comb begin
    res = '0;
    for (int r = pfc_pkg::SIDE - 1; r >= 0; r--) begin
      for (int c = pfc_pkg::SIDE - 1; c >= 0; c--) begin
        if (grid[r][c] == folded) begin
          res.found = 1'b1;
          res.row   = pfc_pkg::pos_t'(r);
          res.col   = pfc_pkg::pos_t'(c);
        end
      end
    end
    if (folded > pfc_pkg::LETTER_MAX) begin
      res.found = 1'b0;
    end
  end

endmodule

// File: design/pfc_merge.sv
module pfc_merge (
  input  pfc_pkg::grid_t     grid,
  input  pfc_pkg::cmd_t      cmd,
  input  pfc_pkg::lane_res_t lane_a,
  input  pfc_pkg::lane_res_t lane_b,
  output pfc_pkg::out_res_t  res
);

  pfc_pkg::pos_t row_a_sh, row_b_sh, col_a_sh, col_b_sh;

  assign row_a_sh = pfc_pkg::step_pos(lane_a.row, cmd);
  assign row_b_sh = pfc_pkg::step_pos(lane_b.row, cmd);
  assign col_a_sh = pfc_pkg::step_pos(lane_a.col, cmd);
  assign col_b_sh = pfc_pkg::step_pos(lane_b.col, cmd);

  // Pick the row, column or rectangle rule and read both result cells
  always_comb begin
    res = '0;
    if (!lane_a.found || !lane_b.found) begin
      res.not_found = 1'b1;
    end else if (lane_a.row == lane_b.row) begin
      res.first_out  = grid[lane_a.row][col_a_sh];
      res.second_out = grid[lane_b.row][col_b_sh];
    end else if (lane_a.col == lane_b.col) begin
      res.first_out  = grid[row_a_sh][lane_a.col];
      res.second_out = grid[row_b_sh][lane_b.col];
    end else begin
      res.first_out  = grid[lane_a.row][lane_b.col];
      res.second_out = grid[lane_b.row][lane_a.col];
    end
  end

endmodule

// File: design/playfair_digraph_cipher.sv
// Channel   Dir  Handshake     Payload
// in_ch     in   valid/ready   cmd, first_letter, second_letter
// out_ch    out  valid/ready   first_out, second_out, not_found
// cfg_*     in   cfg_we only   cfg_index selects the square register, cfg_wdata
//
// Two register stages: two lookup lanes (one per letter) compare against all
// 25 cells and register row/column; the merge stage picks the result cells and
// feeds the output register. One pair per cycle is sustained while out_ch is not stalled.
// Synchronous active-low reset clears the square to zero and empties the pipe.
// A stall on out_ch holds each stage in place; in_ch.ready drops only when both
// stages are full and the output is not taken.
module playfair_digraph_cipher (
  input  logic                              clk,
  input  logic                              rst_n,
  pfc_in_if.sink                            in_ch,
  pfc_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [pfc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pfc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  logic [pfc_pkg::ROWS2_W-1:0] sq01_r, sq23_r;
  logic [pfc_pkg::ROW1_W-1:0]  sq4_r;
  pfc_pkg::grid_t              grid;

  logic                        s1_valid_r;
  pfc_pkg::cmd_t               s1_cmd_r;
  pfc_pkg::lane_res_t          s1_a_r, s1_b_r;
  pfc_pkg::lane_res_t          lane_a, lane_b;

  logic                        out_valid_r;
  pfc_pkg::out_res_t           out_res_r, merge_res;

  logic                        s2_ready;
  logic                        s1_ready;
  logic                        in_xfer;

  assign grid = pfc_pkg::grid_t'({sq4_r, sq23_r, sq01_r});

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq01_r <= '0;
      sq23_r <= '0;
      sq4_r  <= '0;
    end else if (cfg_we) begin
      unique case (pfc_pkg::cfg_reg_t'(cfg_index))
        pfc_pkg::REG_ROWS_0_1: sq01_r <= cfg_wdata;
        pfc_pkg::REG_ROWS_2_3: sq23_r <= cfg_wdata;
        pfc_pkg::REG_ROW_4:    sq4_r  <= cfg_wdata[pfc_pkg::ROW1_W-1:0];
        default: ;
      endcase
    end
  end

  // Lookup lanes, one per letter
  pfc_lane u_lane_a (.grid(grid), .letter(in_ch.first_letter),  .res(lane_a));
  pfc_lane u_lane_b (.grid(grid), .letter(in_ch.second_letter), .res(lane_b));

  // Pipeline flow control
  assign s2_ready    = !out_valid_r || out_ch.ready;
  assign s1_ready    = !s1_valid_r || s2_ready;
  assign in_ch.ready = s1_ready;
  assign in_xfer     = in_ch.valid && s1_ready;

  // Stage 1: hold lane results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_cmd_r <= pfc_pkg::cmd_t'(in_ch.cmd);
      s1_a_r   <= lane_a;
      s1_b_r   <= lane_b;
    end
  end

  // Merge lane results into the output pair
  pfc_merge u_merge (
    .grid  (grid),
    .cmd   (s1_cmd_r),
    .lane_a(s1_a_r),
    .lane_b(s1_b_r),
    .res   (merge_res)
  );

  // Stage 2: output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid_r) begin
      out_res_r <= merge_res;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.first_out  = out_res_r.first_out;
  assign out_ch.second_out = out_res_r.second_out;
  assign out_ch.not_found  = out_res_r.not_found;

  // A missing letter gives zero letters
  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.not_found |->
      out_res_r.first_out == '0 && out_res_r.second_out == '0)
    else $error("not_found result carries nonzero letters");

  // An accepted pair lands in stage 1
  a_in_to_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> s1_valid_r)
    else $error("accepted pair lost before stage 1");

  // A stalled stage 1 keeps its item
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s2_ready |=> s1_valid_r && $stable(s1_a_r) && $stable(s1_b_r))
    else $error("stage 1 item dropped during stall");

  // Stage 1 full feeds the output register when it moves
  a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s2_ready |=> out_valid_r)
    else $error("stage 1 item did not reach output");

endmodule

// File: tb/sv/tb_playfair_digraph_cipher.sv
`timescale 1ns / 100ps

module tb_playfair_digraph_cipher;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int GRID_W = pfc_pkg::SIDE * pfc_pkg::ROW1_W;
  localparam byte CHAR_A = "A";
  localparam byte CHAR_Z = "Z";

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [pfc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [pfc_pkg::CFG_DATA_W-1:0] cfg_wdata;

  pfc_in_if  in_ch ();
  pfc_out_if out_ch ();

  playfair_digraph_cipher u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow of the key square and the pairs still owed by the block
  pfc_pkg::grid_t    key_sq;
  pfc_pkg::out_res_t pair_results_q[$];

  int src_gap_max;
  int sink_stall_max;
  int sink_hold_cycles;
  int n_sent;
  int n_checked;
  int n_absent;
  int n_errors;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Find a letter in the shadow square; J folds to I, first match wins
  function automatic bit locate_letter(input pfc_pkg::letter_t l, output int unsigned row,
                                       output int unsigned col);
    pfc_pkg::letter_t key;
    key = (l == pfc_pkg::LETTER_J) ? pfc_pkg::LETTER_I : l;
    row = 0;
    col = 0;
    if (key > pfc_pkg::LETTER_MAX) return 1'b0;
    for (int r = 0; r < pfc_pkg::SIDE; r++) begin
      for (int c = 0; c < pfc_pkg::SIDE; c++) begin
        if (key_sq[r][c] == key) begin
          row = r;
          col = c;
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  // Playfair substitution of one pair against the shadow square
  function automatic pfc_pkg::out_res_t cipher_pair(pfc_pkg::cmd_t op, pfc_pkg::letter_t a,
                                                    pfc_pkg::letter_t b);
    pfc_pkg::out_res_t res;
    int unsigned r1, c1, r2, c2, shift;
    bit f1, f2;
    res = '0;
    f1 = locate_letter(a, r1, c1);
    f2 = locate_letter(b, r2, c2);
    if (!(f1 && f2)) begin
      res.not_found = 1'b1;
      return res;
    end
    shift = (op == pfc_pkg::CMD_DECRYPT) ? pfc_pkg::SIDE - 1 : 1;
    if (r1 == r2) begin
      res.first_out  = key_sq[r1][(c1 + shift) % pfc_pkg::SIDE];
      res.second_out = key_sq[r2][(c2 + shift) % pfc_pkg::SIDE];
    end else if (c1 == c2) begin
      res.first_out  = key_sq[(r1 + shift) % pfc_pkg::SIDE][c1];
      res.second_out = key_sq[(r2 + shift) % pfc_pkg::SIDE][c2];
    end else begin
      res.first_out  = key_sq[r1][c2];
      res.second_out = key_sq[r2][c1];
    end
    return res;
  endfunction

  // Keyword first, then the rest of the alphabet without J
  function automatic pfc_pkg::grid_t keyword_square(string key);
    pfc_pkg::grid_t g;
    bit used[26];
    int n;
    pfc_pkg::letter_t l;
    g = '0;
    n = 0;
    for (int i = 0; i < key.len(); i++) begin
      if (key[i] >= CHAR_A && key[i] <= CHAR_Z) begin
        l = pfc_pkg::letter_t'(key[i] - CHAR_A);
        if (l == pfc_pkg::LETTER_J) l = pfc_pkg::LETTER_I;
        if (!used[l]) begin
          used[l] = 1'b1;
          g[n / pfc_pkg::SIDE][n % pfc_pkg::SIDE] = l;
          n++;
        end
      end
    end
    for (int i = 0; i <= pfc_pkg::LETTER_MAX; i++) begin
      if (i != pfc_pkg::LETTER_J && !used[i]) begin
        g[n / pfc_pkg::SIDE][n % pfc_pkg::SIDE] = pfc_pkg::letter_t'(i);
        n++;
      end
    end
    return g;
  endfunction

  // Random permutation of the 25 letters
  function automatic pfc_pkg::grid_t shuffled_square();
    pfc_pkg::grid_t g;
    pfc_pkg::letter_t pool[25];
    pfc_pkg::letter_t tmp;
    int n, j;
    n = 0;
    for (int i = 0; i <= pfc_pkg::LETTER_MAX; i++) begin
      if (i != pfc_pkg::LETTER_J) begin
        pool[n] = pfc_pkg::letter_t'(i);
        n++;
      end
    end
    for (int i = 24; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = pool[i];
      pool[i] = pool[j];
      pool[j] = tmp;
    end
    for (int i = 0; i < 25; i++) g[i / pfc_pkg::SIDE][i % pfc_pkg::SIDE] = pool[i];
    return g;
  endfunction

  // Cells with duplicates, J and codes above Z
  function automatic pfc_pkg::grid_t noisy_square();
    pfc_pkg::grid_t g;
    for (int r = 0; r < pfc_pkg::SIDE; r++) begin
      for (int c = 0; c < pfc_pkg::SIDE; c++) begin
        g[r][c] = ($urandom_range(0, 3) == 0) ? pfc_pkg::letter_t'($urandom_range(0, 31))
                                              : pfc_pkg::letter_t'($urandom_range(0, 25));
      end
    end
    return g;
  endfunction

  // Mostly a letter from the given cell, sometimes J for I, any letter or out of range
  function automatic pfc_pkg::letter_t square_letter(int unsigned r, int unsigned c);
    pfc_pkg::letter_t l;
    int sel;
    sel = $urandom_range(0, 19);
    l = key_sq[r][c];
    if (sel == 0) l = pfc_pkg::letter_t'($urandom_range(26, 31));
    else if (sel < 4) l = pfc_pkg::letter_t'($urandom_range(0, 25));
    else if (l == pfc_pkg::LETTER_I && sel < 10) l = pfc_pkg::LETTER_J;
    return l;
  endfunction

  // One register write; caller drops cfg_we after the last one
  task automatic put_reg(pfc_pkg::cfg_reg_t idx, logic [pfc_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      pfc_pkg::REG_ROWS_0_1: key_sq[1:0] = data;
      pfc_pkg::REG_ROWS_2_3: key_sq[3:2] = data;
      pfc_pkg::REG_ROW_4:    key_sq[4]   = data[pfc_pkg::ROW1_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_square(pfc_pkg::grid_t g);
    logic [GRID_W-1:0] flat;
    flat = g;
    put_reg(pfc_pkg::REG_ROWS_0_1, flat[0 +: pfc_pkg::ROWS2_W]);
    put_reg(pfc_pkg::REG_ROWS_2_3, flat[pfc_pkg::ROWS2_W +: pfc_pkg::ROWS2_W]);
    put_reg(pfc_pkg::REG_ROW_4, {{(pfc_pkg::CFG_DATA_W - pfc_pkg::ROW1_W){1'b0}},
                                 flat[2 * pfc_pkg::ROWS2_W +: pfc_pkg::ROW1_W]});
    cfg_we <= 1'b0;
  endtask

  // Offer one pair after a random gap and hold it until the transfer
  task automatic send_pair(pfc_pkg::cmd_t op, pfc_pkg::letter_t a, pfc_pkg::letter_t b);
    int gap;
    gap = $urandom_range(0, src_gap_max);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.cmd           <= op;
    in_ch.first_letter  <= a;
    in_ch.second_letter <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    n_sent++;
  endtask

  // Stop offering and wait until every owed pair has come out
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pair_results_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Pairs biased toward shared rows and columns of the current square
  task automatic send_random_pairs(int count);
    int unsigned r1, c1, r2, c2;
    repeat (count) begin
      r1 = $urandom_range(0, pfc_pkg::SIDE - 1);
      c1 = $urandom_range(0, pfc_pkg::SIDE - 1);
      r2 = $urandom_range(0, pfc_pkg::SIDE - 1);
      c2 = $urandom_range(0, pfc_pkg::SIDE - 1);
      case ($urandom_range(0, 3))
        0: r2 = r1;
        1: c2 = c1;
        default: ;
      endcase
      send_pair(pfc_pkg::cmd_t'($urandom_range(0, 1)), square_letter(r1, c1),
                square_letter(r2, c2));
    end
  endtask

  // Square left at zero by reset: only A is found
  task automatic test_reset_square();
    send_pair(pfc_pkg::CMD_ENCRYPT, 5'd0, 5'd0);
    send_pair(pfc_pkg::CMD_DECRYPT, 5'd0, 5'd0);
    send_pair(pfc_pkg::CMD_ENCRYPT, 5'd0, 5'd1);
    send_pair(pfc_pkg::CMD_DECRYPT, pfc_pkg::LETTER_MAX, 5'd0);
  endtask

  // Classic keyword square: row, column, rectangle, wraps, J, equal letters
  task automatic test_keyword_square();
    drain_results();
    load_square(keyword_square("PLAYFAIREXAMPLE"));
    send_pair(pfc_pkg::CMD_ENCRYPT, 5'd15, 5'd11);
    send_pair(pfc_pkg::CMD_ENCRYPT, 5'd0, 5'd5);
    send_pair(pfc_pkg::CMD_DECRYPT, 5'd15, 5'd24);
    send_pair(pfc_pkg::CMD_ENCRYPT, 5'd15, 5'd19);
    send_pair(pfc_pkg::CMD_DECRYPT, 5'd8, 5'd1);
    send_pair(pfc_pkg::CMD_ENCRYPT, 5'd7, 5'd8);
    send_pair(pfc_pkg::CMD_DECRYPT, 5'd1, 5'd12);
    send_pair(pfc_pkg::CMD_ENCRYPT, pfc_pkg::LETTER_J, 5'd23);
    send_pair(pfc_pkg::CMD_DECRYPT, 5'd17, pfc_pkg::LETTER_J);
    send_pair(pfc_pkg::CMD_ENCRYPT, 5'd4, 5'd4);
    send_pair(pfc_pkg::CMD_DECRYPT, pfc_pkg::LETTER_MAX, pfc_pkg::LETTER_MAX);
    send_pair(pfc_pkg::CMD_ENCRYPT, 5'd26, 5'd0);
    send_pair(pfc_pkg::CMD_DECRYPT, 5'd0, 5'd31);
  endtask

  // Odd cell contents, then the all-ones and all-zero extremes
  task automatic test_odd_squares();
    pfc_pkg::grid_t g;
    drain_results();
    g = keyword_square("PLAYFAIREXAMPLE");
    g[0][0] = pfc_pkg::LETTER_J;
    g[1][1] = 5'd30;
    g[4][4] = g[0][1];
    load_square(g);
    send_pair(pfc_pkg::CMD_DECRYPT, 5'd11, 5'd0);
    send_pair(pfc_pkg::CMD_ENCRYPT, 5'd8, 5'd2);
    send_pair(pfc_pkg::CMD_ENCRYPT, 5'd8, 5'd17);
    send_pair(pfc_pkg::CMD_ENCRYPT, 5'd24, 5'd25);
    send_pair(pfc_pkg::CMD_ENCRYPT, pfc_pkg::LETTER_J, pfc_pkg::LETTER_J);
    drain_results();
    load_square('1);
    send_pair(pfc_pkg::CMD_ENCRYPT, 5'd0, 5'd1);
    send_pair(pfc_pkg::CMD_DECRYPT, pfc_pkg::LETTER_MAX, pfc_pkg::LETTER_MAX);
    drain_results();
    load_square('0);
    send_pair(pfc_pkg::CMD_ENCRYPT, 5'd0, 5'd0);
  endtask

  // Fresh permutations with the idle pattern changing per square
  task automatic test_random_squares();
    for (int k = 0; k < 6; k++) begin
      drain_results();
      src_gap_max    = (k % 3 == 2) ? 0 : 5;
      sink_stall_max = (k % 3 == 1) ? 0 : 5;
      load_square(shuffled_square());
      send_random_pairs(40);
    end
    src_gap_max    = 5;
    sink_stall_max = 5;
  endtask

  task automatic test_noisy_squares();
    repeat (3) begin
      drain_results();
      load_square(noisy_square());
      send_random_pairs(25);
    end
  endtask

  // Sink holds off while the source keeps offering, so the pipe fills
  task automatic test_output_hold();
    drain_results();
    load_square(shuffled_square());
    src_gap_max = 0;
    sink_hold_cycles = 60;
    send_random_pairs(40);
    src_gap_max = 5;
  endtask

  // Source stops until every owed pair is out, then resumes
  task automatic test_sender_pause();
    send_random_pairs(25);
    drain_results();
    send_random_pairs(25);
  endtask

  // Rewrite one register at a time, including the all-ones extremes
  task automatic test_register_rewrite();
    pfc_pkg::grid_t g;
    logic [GRID_W-1:0] flat;
    drain_results();
    g = noisy_square();
    flat = g;
    put_reg(pfc_pkg::REG_ROWS_2_3, flat[pfc_pkg::ROWS2_W +: pfc_pkg::ROWS2_W]);
    cfg_we <= 1'b0;
    send_random_pairs(15);
    drain_results();
    put_reg(pfc_pkg::REG_ROW_4, {{(pfc_pkg::CFG_DATA_W - pfc_pkg::ROW1_W){1'b0}},
                                 {pfc_pkg::ROW1_W{1'b1}}});
    cfg_we <= 1'b0;
    send_random_pairs(15);
    drain_results();
    put_reg(pfc_pkg::REG_ROWS_0_1, {pfc_pkg::ROWS2_W{1'b1}});
    cfg_we <= 1'b0;
    send_random_pairs(15);
  endtask

  // Predict on every input transfer
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      pair_results_q.push_back(cipher_pair(pfc_pkg::cmd_t'(in_ch.cmd), in_ch.first_letter,
                                           in_ch.second_letter));
    end
  end

  // Compare every output transfer with the oldest prediction
  always @(posedge clk) begin : check_results
    pfc_pkg::out_res_t exp_res;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_checked++;
      if (pair_results_q.size() == 0) begin
        $display("%0t: unexpected result %0d %0d %0d", $time, out_ch.first_out,
                 out_ch.second_out, out_ch.not_found);
        n_errors++;
      end else begin
        exp_res = pair_results_q.pop_front();
        if (exp_res.not_found) n_absent++;
        if (out_ch.first_out !== exp_res.first_out) begin
          $display("%0t: first_out expected %0d got %0d", $time, exp_res.first_out,
                   out_ch.first_out);
          n_errors++;
        end
        if (out_ch.second_out !== exp_res.second_out) begin
          $display("%0t: second_out expected %0d got %0d", $time, exp_res.second_out,
                   out_ch.second_out);
          n_errors++;
        end
        if (out_ch.not_found !== exp_res.not_found) begin
          $display("%0t: not_found expected %0d got %0d", $time, exp_res.not_found,
                   out_ch.not_found);
          n_errors++;
        end
      end
    end
  end

  // Sink: random stall before each transfer, or one long hold on request
  initial begin : result_sink
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (sink_hold_cycles > 0) begin
        stall = sink_hold_cycles;
        sink_hold_cycles = 0;
      end else begin
        stall = $urandom_range(0, sink_stall_max);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (out_ch.valid !== 1'b1) @(posedge clk);
    end
  end

  // Abort when no transfer happens on either side for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no transfer for %0d cycles, %0d results owed", $time, WATCHDOG_LIMIT,
             pair_results_q.size());
    $display("[playfair_digraph_cipher] ERROR");
    $finish;
  end

  initial begin
    src_gap_max      = 5;
    sink_stall_max   = 5;
    sink_hold_cycles = 0;
    n_sent           = 0;
    n_checked        = 0;
    n_absent         = 0;
    n_errors         = 0;
    key_sq           = '0;
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_index           <= pfc_pkg::REG_ROWS_0_1;
    cfg_wdata           <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.cmd           <= pfc_pkg::CMD_ENCRYPT;
    in_ch.first_letter  <= '0;
    in_ch.second_letter <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_square();
    test_keyword_square();
    test_odd_squares();
    test_random_squares();
    test_noisy_squares();
    test_output_hold();
    test_sender_pause();
    test_register_rewrite();
    drain_results();

    $display("Sent %0d pairs, checked %0d results, %0d with a letter missing", n_sent,
             n_checked, n_absent);
    $display("Squares: reset, keyword, shuffled, noisy, all-ones; long output hold, pause");
    if (n_errors == 0 && pair_results_q.size() == 0) begin
      $display("[playfair_digraph_cipher] OK");
    end else begin
      $display("[playfair_digraph_cipher] ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
design/pfc_pkg.sv
design/pfc_in_if.sv
design/pfc_out_if.sv
design/pfc_lane.sv
design/pfc_merge.sv
design/playfair_digraph_cipher.sv
tb/sv/tb_playfair_digraph_cipher.sv
